[hw/rtl/mqrm_pkg.sv]
// Shared command and status codes for the multi-queue ring manager.
package mqrm_pkg;

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_RECEIVE = 2'd1;
  localparam logic [1:0] CMD_CREATE  = 2'd2;
  localparam logic [1:0] CMD_DELETE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;
  localparam logic [1:0] ST_NO_DATA = 2'd3;

  typedef logic [1:0] status_t;

endpackage

[hw/rtl/multi_queue_ring_manager.sv]
// Top level of the multi-queue ring manager: pointer memory, message store and sequencer.
// The block serves one request at a time. A request is taken in the idle cycle, the queue's
// pointer pair is read from the pointer memory, and the next cycle checks, updates
// and writes it back. Send, create and delete end there; a receive that returns data
// adds a read of the message store. in_stall stays high while a request is in work;
// a finished result waits in the output register while the next request is taken, and
// the sequencer waits only if that register is still full and stalled when the next
// result is ready. Read and write pointers reset to zero through one valid bit per queue,
// and all dynamic queues start free.
module multi_queue_ring_manager #(
  parameter int NUM_QUEUES        = 16,
  parameter int NUM_STATIC_QUEUES = 4,
  parameter int QUEUE_DEPTH       = 16,
  parameter int HANDLE_WIDTH      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_queue_id,
  input  logic [31:0] in_msg_handle,
  input  logic [15:0] in_msg_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_handle_out,
  output logic [15:0] out_size_out,
  output logic [3:0]  out_new_queue_id
);

  localparam int QW  = $clog2(NUM_QUEUES);
  localparam int QXW = (QW > 4) ? QW : 4;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int SAW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int HSW = (HANDLE_WIDTH < 32) ? HANDLE_WIDTH : 32;
  localparam int CW  = (NUM_QUEUES < 16) ? NUM_QUEUES : 16;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PTR  = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [1:0]  cmd_r;
  logic [3:0]  qid_r;
  logic [31:0] handle_r;
  logic [15:0] size_r;

  logic [2*PW-1:0] ptr_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] ptr_vld_r;
  logic [2*PW-1:0] ptr_rd_r;
  logic            ptr_vld_rd_r;

  logic [HSW-1:0] h_mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [15:0]    s_mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [HSW-1:0] h_rd_r;
  logic [15:0]    s_rd_r;

  logic [CW-1:0] claim_r;

  logic [1:0]  hold_status_r;
  logic [31:0] hold_handle_r;
  logic [15:0] hold_size_r;
  logic [3:0]  hold_id_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_handle_r;
  logic [15:0] out_size_r;
  logic [3:0]  out_id_r;

  logic           accept;
  logic           out_free;
  logic [QXW-1:0] in_q_ext;
  logic [QXW-1:0] cur_q_ext;
  logic [QW-1:0]  in_qi;
  logic [QW-1:0]  cur_qi;
  logic [PW-1:0]  wp, rp, wp_adv, rp_adv;
  logic           q_bad, q_static;
  logic           found;
  logic [3:0]     free_id;
  logic [SAW-1:0] st_addr;

  mqrm_pkg::status_t res_status;
  logic [3:0]        res_id;
  logic              do_ptr_wr, do_st_wr, do_st_rd, do_claim, do_free;
  logic [2*PW-1:0]   ptr_wr_data;

  mqrm_pkg::status_t ld_status;
  logic [31:0]       ld_handle;
  logic [15:0]       ld_size;
  logic [3:0]        ld_id;
  logic              ld_out;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign in_q_ext  = QXW'(in_queue_id);
  assign cur_q_ext = QXW'(qid_r);
  assign in_qi     = in_q_ext[QW-1:0];
  assign cur_qi    = cur_q_ext[QW-1:0];

  assign wp = ptr_vld_rd_r ? ptr_rd_r[2*PW-1:PW] : '0;
  assign rp = ptr_vld_rd_r ? ptr_rd_r[PW-1:0] : '0;
  assign wp_adv = (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_adv = (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;

  assign q_bad    = (9'(qid_r) >= 9'(NUM_QUEUES));
  assign q_static = (9'(qid_r) < 9'(NUM_STATIC_QUEUES));

  always_comb begin
    found   = 1'b0;
    free_id = '0;
    for (int i = 0; i < CW; i++) begin
      if ((i >= NUM_STATIC_QUEUES) && !found && !claim_r[i]) begin
        found   = 1'b1;
        free_id = 4'(i);
      end
    end
  end

  always_comb begin
    res_status  = mqrm_pkg::ST_OK;
    res_id      = '0;
    do_ptr_wr   = 1'b0;
    do_st_wr    = 1'b0;
    do_st_rd    = 1'b0;
    do_claim    = 1'b0;
    do_free     = 1'b0;
    ptr_wr_data = {wp, rp};
    st_addr     = SAW'(rp);
    if (cmd_r == mqrm_pkg::CMD_CREATE) begin
      if (found) begin
        res_id   = free_id;
        do_claim = 1'b1;
      end else begin
        res_status = mqrm_pkg::ST_FULL;
      end
    end else if (q_bad) begin
      res_status = mqrm_pkg::ST_BAD_ID;
    end else begin
      case (cmd_r)
        mqrm_pkg::CMD_DELETE: begin
          if (q_static) begin
            res_status = mqrm_pkg::ST_BAD_ID;
          end else begin
            do_free = 1'b1;
          end
        end
        mqrm_pkg::CMD_SEND: begin
          st_addr = SAW'(cur_qi) * SAW'(QUEUE_DEPTH) + SAW'(wp);
          if (wp_adv == rp) begin
            res_status = mqrm_pkg::ST_FULL;
          end else begin
            do_st_wr    = 1'b1;
            do_ptr_wr   = 1'b1;
            ptr_wr_data = {wp_adv, rp};
          end
        end
        default: begin
          st_addr = SAW'(cur_qi) * SAW'(QUEUE_DEPTH) + SAW'(rp);
          if (rp == wp) begin
            res_status = mqrm_pkg::ST_NO_DATA;
          end else begin
            do_st_rd    = 1'b1;
            do_ptr_wr   = 1'b1;
            ptr_wr_data = {wp, rp_adv};
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ld_out    = 1'b0;
    ld_status = hold_status_r;
    ld_handle = hold_handle_r;
    ld_size   = hold_size_r;
    ld_id     = hold_id_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PTR;
        end
      end
      S_PTR: begin
        ld_status = res_status;
        ld_handle = '0;
        ld_size   = '0;
        ld_id     = res_id;
        if (do_st_rd) begin
          state_nxt = S_DATA;
        end else if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_DATA: begin
        ld_status = mqrm_pkg::ST_OK;
        ld_handle = 32'(h_rd_r);
        ld_size   = s_rd_r;
        ld_id     = '0;
        if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ptr_vld_r   <= '0;
      claim_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_PTR) && do_ptr_wr) begin
        ptr_vld_r[cur_qi] <= 1'b1;
      end
      if (state_r == S_PTR) begin
        for (int i = 0; i < CW; i++) begin
          if (do_claim && (4'(i) == free_id)) begin
            claim_r[i] <= 1'b1;
          end
          if (do_free && (4'(i) == qid_r)) begin
            claim_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_cmd;
      qid_r        <= in_queue_id;
      handle_r     <= in_msg_handle;
      size_r       <= in_msg_size;
      ptr_rd_r     <= ptr_mem[in_qi];
      ptr_vld_rd_r <= ptr_vld_r[in_qi];
    end
    if ((state_r == S_PTR) && do_ptr_wr) begin
      ptr_mem[cur_qi] <= ptr_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_PTR) && do_st_wr) begin
      h_mem[st_addr] <= handle_r[HSW-1:0];
      s_mem[st_addr] <= size_r;
    end
    if ((state_r == S_PTR) && do_st_rd) begin
      h_rd_r <= h_mem[st_addr];
      s_rd_r <= s_mem[st_addr];
    end
  end

  always_ff @(posedge clk) begin
    if ((state_nxt == S_HOLD) && (state_r != S_HOLD)) begin
      hold_status_r <= ld_status;
      hold_handle_r <= ld_handle;
      hold_size_r   <= ld_size;
      hold_id_r     <= ld_id;
    end
    if (ld_out) begin
      out_status_r <= ld_status;
      out_handle_r <= ld_handle;
      out_size_r   <= ld_size;
      out_id_r     <= ld_id;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_handle_out   = out_handle_r;
  assign out_size_out     = out_size_r;
  assign out_new_queue_id = out_id_r;

endmodule

[hw/rtl/mqrm_checker.sv]
// Port-level checker for the multi-queue ring manager and its bind statement.
module mqrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_handle_out,
  input logic [15:0] out_size_out,
  input logic [3:0]  out_new_queue_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_handle_out) && $stable(out_size_out) && $stable(out_new_queue_id))
    else $error("Stalled result changed or vanished.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Second request taken while the first was still in work.");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mqrm_pkg::ST_OK) |-> (out_handle_out == '0)
      && (out_size_out == '0) && (out_new_queue_id == '0))
    else $error("Failed request returned nonzero payload.");

  a_id_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_queue_id != '0) |-> (out_status == mqrm_pkg::ST_OK)
      && (out_handle_out == '0) && (out_size_out == '0))
    else $error("Queue id returned with a non-create result.");

endmodule

bind multi_queue_ring_manager mqrm_checker u_mqrm_checker (.*);
